@@ rtl/dlst_pkg.sv @@
// ----------------------------------------------------------------------------
// dlst_pkg
// Shared types and constants for the delta-list sleep timer queue.
// ----------------------------------------------------------------------------
package dlst_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int NRES_W          = $clog2(MAX_RESULTS + 1);

  // operation codes carried on s_tuser
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // result kinds carried on m_tuser
  localparam logic KIND_WAKE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic [15:0] delta;
    logic [15:0] sem;
    logic [15:0] thread;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REJ,
    S_AW_RD, S_AW_CK, S_AS_RD, S_AS_WR, S_A_FIX, S_A_NEW,
    S_RW_RD, S_RW_CK, S_RS_RD, S_RS_WR,
    S_T_RD, S_T_CK, S_T_FLUSH
  } state_t;

endpackage

@@ rtl/dlst_ram.sv @@
// ----------------------------------------------------------------------------
// dlst_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dlst_ram #(
  parameter int DEPTH = dlst_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  dlst_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output dlst_pkg::entry_t rdata
);

  dlst_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/delta_list_sleep_timer_queue_top.sv @@
// ----------------------------------------------------------------------------
// delta_list_sleep_timer_queue_top
// Timed-wait queue kept as a delta list in a circular entry memory.
//
//  channel | dir | tdata                                        | tuser     | tlast
//  s_*     | in  | thread_id[15:0] sem_id[31:16] sleep_time[47:32] | func[1:0] | -
//  m_*     | out | woken_thread[15:0] woken_sem[31:16]           | kind      | last_of_run
//
// Walks and shifts go one entry at a time, paced by the single read port of
// the entry memory. Reset (rst, synchronous) empties the queue; the memory is
// not cleared. Input is taken only between requests; a stalled output holds
// the sequencer only when it has a result to hand over.
// ----------------------------------------------------------------------------
module delta_list_sleep_timer_queue_top #(
  parameter int QUEUE_DEPTH = dlst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // thread_id, sem_id, sleep_time
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // woken_thread, woken_sem
  output logic        m_tuser,   // kind
  output logic        m_tlast    // last_of_run
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = dlst_pkg::NRES_W;

  dlst_pkg::state_t st, st_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    jdx, jdx_next;
  logic [CW-1:0]    pos, pos_next;
  logic [16:0]      cum, cum_next;
  logic [15:0]      nd, nd_next;
  logic [15:0]      dfold, dfold_next;
  logic [15:0]      r_thr, r_sem, r_tm;
  logic             dec, dec_next;
  logic [NW-1:0]    nres, nres_next;
  dlst_pkg::entry_t old, old_next;
  dlst_pkg::entry_t pend, pend_next;
  logic             pvld, pvld_next;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  dlst_pkg::entry_t mem_wdata, rdata;

  logic             push, push_kind, push_last;
  logic [31:0]      push_data;
  logic             out_free;
  logic             in_acc;

  logic [16:0]      sum;
  logic [15:0]      dv;

  // logical position to memory address, wrapping around the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dlst_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign s_tready = (st == dlst_pkg::S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sum      = cum + 17'(rdata.delta);
  assign dv       = (dec && rdata.delta != 16'd0) ? rdata.delta - 16'd1 : rdata.delta;

  // sequencer: next state, memory accesses and results
  always_comb begin
    st_next    = st;
    cnt_next   = cnt;
    head_next  = head;
    idx_next   = idx;
    jdx_next   = jdx;
    pos_next   = pos;
    cum_next   = cum;
    nd_next    = nd;
    dfold_next = dfold;
    dec_next   = dec;
    nres_next  = nres;
    old_next   = old;
    pend_next  = pend;
    pvld_next  = pvld;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = phys(head, jdx);
    mem_raddr  = phys(head, idx);
    mem_wdata  = rdata;
    push       = 1'b0;
    push_kind  = dlst_pkg::KIND_WAKE;
    push_last  = 1'b0;
    push_data  = {pend.sem, pend.thread};

    unique case (st)
      dlst_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_next = '0;
          cum_next = '0;
          priority case (s_tuser)
            dlst_pkg::FUNC_ADD: begin
              st_next = (cnt == CW'(QUEUE_DEPTH)) ? dlst_pkg::S_REJ : dlst_pkg::S_AW_RD;
            end
            dlst_pkg::FUNC_TICK: begin
              dec_next  = 1'b1;
              nres_next = '0;
              st_next   = dlst_pkg::S_T_RD;
            end
            dlst_pkg::FUNC_REMOVE: st_next = dlst_pkg::S_RW_RD;
            default: st_next = dlst_pkg::S_IDLE;
          endcase
        end
      end

      // reject an add to a full queue
      dlst_pkg::S_REJ: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = dlst_pkg::KIND_REJECT;
          push_last = 1'b1;
          push_data = {r_sem, r_thr};
          st_next   = dlst_pkg::S_IDLE;
        end
      end

      // walk to the insert point
      dlst_pkg::S_AW_RD: begin
        if (idx == cnt) begin
          pos_next = cnt;
          nd_next  = r_tm - cum[15:0];
          jdx_next = cnt;
          st_next  = dlst_pkg::S_AS_RD;
        end else begin
          mem_re  = 1'b1;
          st_next = dlst_pkg::S_AW_CK;
        end
      end
      dlst_pkg::S_AW_CK: begin
        if (17'(r_tm) <= sum) begin
          pos_next = idx;
          old_next = rdata;
          nd_next  = r_tm - cum[15:0];
          jdx_next = cnt;
          st_next  = dlst_pkg::S_AS_RD;
        end else begin
          cum_next = sum;
          idx_next = idx + CW'(1);
          st_next  = dlst_pkg::S_AW_RD;
        end
      end

      // shift the tail up by one entry
      dlst_pkg::S_AS_RD: begin
        if ((CW+1)'(jdx) > (CW+1)'(pos) + (CW+1)'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head, jdx - CW'(1));
          st_next   = dlst_pkg::S_AS_WR;
        end else if (pos < cnt) begin
          st_next = dlst_pkg::S_A_FIX;
        end else begin
          st_next = dlst_pkg::S_A_NEW;
        end
      end
      dlst_pkg::S_AS_WR: begin
        mem_we   = 1'b1;
        jdx_next = jdx - CW'(1);
        st_next  = dlst_pkg::S_AS_RD;
      end
      dlst_pkg::S_A_FIX: begin
        mem_we          = 1'b1;
        mem_waddr       = phys(head, pos + CW'(1));
        mem_wdata       = old;
        mem_wdata.delta = old.delta - nd;
        st_next         = dlst_pkg::S_A_NEW;
      end
      dlst_pkg::S_A_NEW: begin
        mem_we           = 1'b1;
        mem_waddr        = phys(head, pos);
        mem_wdata.thread = r_thr;
        mem_wdata.sem    = r_sem;
        mem_wdata.delta  = nd;
        cnt_next         = cnt + CW'(1);
        st_next          = dlst_pkg::S_IDLE;
      end

      // search for the named thread
      dlst_pkg::S_RW_RD: begin
        if (idx == cnt) begin
          st_next = dlst_pkg::S_IDLE;
        end else begin
          mem_re  = 1'b1;
          st_next = dlst_pkg::S_RW_CK;
        end
      end
      dlst_pkg::S_RW_CK: begin
        if (rdata.thread == r_thr) begin
          dfold_next = rdata.delta;
          jdx_next   = idx;
          st_next    = dlst_pkg::S_RS_RD;
        end else begin
          idx_next = idx + CW'(1);
          st_next  = dlst_pkg::S_RW_RD;
        end
      end

      // shift the tail down, folding the removed delta into the successor
      dlst_pkg::S_RS_RD: begin
        if ((CW+1)'(jdx) + (CW+1)'(1) < (CW+1)'(cnt)) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head, jdx + CW'(1));
          st_next   = dlst_pkg::S_RS_WR;
        end else begin
          cnt_next = cnt - CW'(1);
          st_next  = dlst_pkg::S_IDLE;
        end
      end
      dlst_pkg::S_RS_WR: begin
        mem_we          = 1'b1;
        mem_wdata.delta = rdata.delta + dfold;
        dfold_next      = '0;
        jdx_next        = jdx + CW'(1);
        st_next         = dlst_pkg::S_RS_RD;
      end

      // tick: decrement the head once, then pop due entries
      dlst_pkg::S_T_RD: begin
        if (cnt == '0 || nres == NW'(dlst_pkg::MAX_RESULTS)) begin
          st_next = pvld ? dlst_pkg::S_T_FLUSH : dlst_pkg::S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head;
          st_next   = dlst_pkg::S_T_CK;
        end
      end
      dlst_pkg::S_T_CK: begin
        if (dv != 16'd0) begin
          if (dec) begin
            mem_we          = 1'b1;
            mem_waddr       = head;
            mem_wdata.delta = dv;
          end
          dec_next = 1'b0;
          st_next  = pvld ? dlst_pkg::S_T_FLUSH : dlst_pkg::S_IDLE;
        end else if (!pvld || out_free) begin
          push      = pvld;
          pend_next = rdata;
          pvld_next = 1'b1;
          dec_next  = 1'b0;
          head_next = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
          cnt_next  = cnt - CW'(1);
          nres_next = nres + NW'(1);
          st_next   = dlst_pkg::S_T_RD;
        end
      end
      dlst_pkg::S_T_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pvld_next = 1'b0;
          st_next   = dlst_pkg::S_IDLE;
        end
      end
      default: st_next = dlst_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= dlst_pkg::S_IDLE;
      cnt      <= '0;
      head     <= '0;
      pvld     <= 1'b0;
      dec      <= 1'b0;
      nres     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      st   <= st_next;
      cnt  <= cnt_next;
      head <= head_next;
      pvld <= pvld_next;
      dec  <= dec_next;
      nres <= nres_next;
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx   <= idx_next;
    jdx   <= jdx_next;
    pos   <= pos_next;
    cum   <= cum_next;
    nd    <= nd_next;
    dfold <= dfold_next;
    old   <= old_next;
    pend  <= pend_next;
    if (in_acc) begin
      r_thr <= s_tdata[15:0];
      r_sem <= s_tdata[31:16];
      r_tm  <= s_tdata[47:32];
    end
    if (push) begin
      m_tdata <= push_data;
      m_tuser <= push_kind;
      m_tlast <= push_last;
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH)) else $error("entry count beyond depth");
  a_rej_full: assert property (@(posedge clk) disable iff (rst)
    st == dlst_pkg::S_REJ |-> cnt == CW'(QUEUE_DEPTH)) else $error("reject while not full");
  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pvld |-> (st == dlst_pkg::S_T_RD || st == dlst_pkg::S_T_CK || st == dlst_pkg::S_T_FLUSH))
    else $error("pending wake outside tick");
  a_nres: assert property (@(posedge clk) disable iff (rst)
    nres <= NW'(dlst_pkg::MAX_RESULTS)) else $error("too many wakes in one tick");

endmodule

@@ verif/delta_list_sleep_timer_queue_checker.sv @@
// ----------------------------------------------------------------------------
// delta_list_sleep_timer_queue_checker
// Watches both stream channels, keeps a delta-list model of the sleep queue
// and compares every wake or reject result with the predicted one.
// ----------------------------------------------------------------------------
module delta_list_sleep_timer_queue_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // thread_id, sem_id, sleep_time
  input  logic [1:0]  s_tuser,   // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // woken_thread, woken_sem
  input  logic        m_tuser,   // kind
  input  logic        m_tlast,   // last_of_run
  output int          fail_count,
  output int          pending,
  output int          sleeper_count
);

  localparam int DEPTH = dlst_pkg::QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic        kind;
    logic [15:0] thread;
    logic [15:0] sem;
    logic        last;
  } wake_t;

  logic [15:0] q_thread [DEPTH];
  logic [15:0] q_sem    [DEPTH];
  logic [15:0] q_delta  [DEPTH];
  int          q_len;
  wake_t       wake_q [$];

  assign pending       = wake_q.size();
  assign sleeper_count = q_len;

  // close the gap at pos by moving later entries toward the head
  function automatic void drop_sleeper(int pos);
    for (int i = pos; i + 1 < q_len; i++) begin
      q_thread[i] = q_thread[i+1];
      q_sem[i]    = q_sem[i+1];
      q_delta[i]  = q_delta[i+1];
    end
    q_len--;
  endfunction

  function automatic void predict_request(logic [1:0] func, logic [15:0] thr,
                                          logic [15:0] sem, logic [15:0] tm);
    int    cum, prevcum, pos, nd, n;
    wake_t w;
    cum = 0; prevcum = 0; pos = 0; n = 0;
    case (func)
      dlst_pkg::FUNC_ADD: begin
        if (q_len >= DEPTH) begin
          w = '{dlst_pkg::KIND_REJECT, thr, sem, 1'b1};
          wake_q.push_back(w);
        end else begin
          for (int i = 0; i < q_len; i++) begin
            cum += q_delta[i];
            if (int'(tm) <= cum) break;
            prevcum = cum;
            pos = i + 1;
          end
          nd = int'(tm) - prevcum;
          if (pos < q_len) q_delta[pos] = q_delta[pos] - nd[15:0];
          for (int i = q_len; i > pos; i--) begin
            q_thread[i] = q_thread[i-1];
            q_sem[i]    = q_sem[i-1];
            q_delta[i]  = q_delta[i-1];
          end
          q_thread[pos] = thr;
          q_sem[pos]    = sem;
          q_delta[pos]  = nd[15:0];
          q_len++;
        end
      end
      dlst_pkg::FUNC_TICK: begin
        if (q_len > 0 && q_delta[0] != 0) q_delta[0]--;
        while (q_len > 0 && q_delta[0] == 0 && n < dlst_pkg::MAX_RESULTS) begin
          w = '{dlst_pkg::KIND_WAKE, q_thread[0], q_sem[0], 1'b0};
          wake_q.push_back(w);
          drop_sleeper(0);
          n++;
        end
        if (n > 0) wake_q[$].last = 1'b1;
      end
      dlst_pkg::FUNC_REMOVE: begin
        for (int i = 0; i < q_len; i++) begin
          if (q_thread[i] == thr) begin
            if (i + 1 < q_len) q_delta[i+1] = q_delta[i+1] + q_delta[i];
            drop_sleeper(i);
            break;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    wake_t e;
    int    errs;
    errs = 0;
    if (rst) begin
      q_len = 0;
      fail_count <= 0;
      wake_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        predict_request(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
      if (m_tvalid && m_tready) begin
        if (wake_q.size() == 0) begin
          $error("unexpected result thread=%h", m_tdata[15:0]);
          errs++;
        end else begin
          e = wake_q.pop_front();
          if (m_tuser !== e.kind) begin
            $error("kind exp %h got %h", e.kind, m_tuser);
            errs++;
          end
          if (m_tdata[15:0] !== e.thread) begin
            $error("woken_thread exp %h got %h", e.thread, m_tdata[15:0]);
            errs++;
          end
          if (m_tdata[31:16] !== e.sem) begin
            $error("woken_sem exp %h got %h", e.sem, m_tdata[31:16]);
            errs++;
          end
          if (m_tlast !== e.last) begin
            $error("last_of_run exp %h got %h", e.last, m_tlast);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ verif/delta_list_sleep_timer_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// delta_list_sleep_timer_queue_top_tb
// Drives add, tick and remove requests with random gaps and output stalls,
// including a long receiver hold-off that fills the queue, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module delta_list_sleep_timer_queue_top_tb;

  localparam int LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          fail_count, pending, sleeper_count;
  int          cycles = 0;
  bit          hold_off = 1'b0;
  logic [15:0] recent_thr [8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  delta_list_sleep_timer_queue_top dut (.*);

  delta_list_sleep_timer_queue_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one request and wait for its acceptance; valid stays high
  task automatic send_request(logic [1:0] func, logic [15:0] thr,
                              logic [15:0] sem, logic [15:0] tm);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {tm, sem, thr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    recent_thr[$urandom_range(0, 7)] = thr;
  endtask

  task automatic send_gapped(logic [1:0] func, logic [15:0] thr,
                             logic [15:0] sem, logic [15:0] tm);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    send_request(func, thr, sem, tm);
  endtask

  // idle the input until every predicted result has come
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver stalls at random, or holds off for a long stretch on request
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      m_tready <= 1'b1;
      g = $urandom_range(0, 3) == 0 ? gap_len() : 0;
      if (g > 0) begin
        @(posedge clk);
        m_tready <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    logic [1:0]  f;
    logic [15:0] thr, tm;
    for (int i = 0; i < 8; i++) recent_thr[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tick, zero timeout, extremes, ties, remove cases
    send_request(dlst_pkg::FUNC_TICK, 16'h0, 16'h0, 16'h0);
    send_request(dlst_pkg::FUNC_REMOVE, 16'h1234, 16'h0, 16'h0);
    send_request(dlst_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_request(dlst_pkg::FUNC_TICK, 16'h0, 16'h0, 16'h0);
    send_request(dlst_pkg::FUNC_ADD, 16'h0001, 16'h00AA, 16'h0005);
    send_request(dlst_pkg::FUNC_REMOVE, 16'h0001, 16'h0, 16'h0);
    send_request(dlst_pkg::FUNC_ADD, 16'h0002, 16'h5555, 16'h0002);
    send_request(dlst_pkg::FUNC_ADD, 16'h0003, 16'hAAAA, 16'h0002);
    send_request(dlst_pkg::FUNC_ADD, 16'h0003, 16'h1111, 16'h0004);
    send_request(dlst_pkg::FUNC_ADD, 16'h0000, 16'h0000, 16'hFFFF);
    send_request(dlst_pkg::FUNC_REMOVE, 16'h0003, 16'h0, 16'h0);
    send_request(dlst_pkg::FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_request(dlst_pkg::FUNC_TICK, 16'h0, 16'h0, 16'h0);
    send_request(dlst_pkg::FUNC_REMOVE, 16'h0000, 16'h0, 16'h0);
    drain();

    // fill past capacity with equal timeouts while the receiver holds off
    hold_off = 1'b1;
    for (int i = 0; i < 18; i++)
      send_request(dlst_pkg::FUNC_ADD, 16'(16'h100 + i), 16'(i), 16'h0001);
    for (int i = 0; i < 3; i++) send_request(dlst_pkg::FUNC_TICK, 16'h0, 16'h0, 16'h0);
    drain();

    // random: mostly adds and ticks with short timeouts, some removes
    for (int i = 0; i < 210; i++) begin
      r = $urandom_range(0, 99);
      thr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
      tm = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      if (r < 45) f = dlst_pkg::FUNC_ADD;
      else if (r < 80) f = dlst_pkg::FUNC_TICK;
      else if (r < 97) f = dlst_pkg::FUNC_REMOVE;
      else f = dlst_pkg::FUNC_NONE;
      if (f == dlst_pkg::FUNC_REMOVE && $urandom_range(0, 1))
        thr = recent_thr[$urandom_range(0, 7)];
      send_gapped(f, thr, 16'($urandom), tm);
      if (i == 105) drain();
    end
    // flush remaining sleepers with back-to-back removes of recent threads
    for (int i = 0; i < 40 && sleeper_count != 0; i++)
      send_request(dlst_pkg::FUNC_REMOVE, recent_thr[i % 8], 16'h0, 16'h0);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
